>>> rtl/core/e2g_pkg.sv
// ============================================================================
// e2g_pkg: shared definitions for the ECEF to geodetic converter
// Fixed-point constants, control structs and small arithmetic helpers.
// ============================================================================
package e2g_pkg;

    // Angles are Q30 radians held in 36-bit signed words.
    localparam logic signed [35:0] PI_Q30     = 36'sd3373259426;
    localparam logic signed [35:0] HALFPI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] TWOPI_Q30  = 36'sd6746518852;
    localparam logic signed [35:0] DEG_Q30    = 36'sd18740330;
    localparam logic signed [35:0] TEN_Q30    = 36'sd10737418240;
    localparam logic signed [39:0] ONE_Q30    = 40'sd1073741824;
    localparam logic signed [32:0] E2_Q30     = 33'sd7188041;
    localparam logic signed [32:0] OMEGA_Q30  = 33'sd1066553783;
    localparam logic signed [32:0] KGAIN_Q32  = 33'sd2608131496;
    localparam logic signed [63:0] KGAIN_Q30  = 64'sd652032874;
    localparam logic [62:0]        QCAP       = 63'd1 << 62;
    localparam logic signed [63:0] ALT_MAX    = 64'sd1099511627775;
    localparam logic signed [63:0] ALT_MIN    = -64'sd1099511627776;

    // Register reset values.
    localparam logic [5:0]  MAXIT_RESET  = 6'd10;
    localparam logic [33:0] TOL_RESET    = 34'd1074;
    localparam logic [32:0] RADIUS_RESET = 33'd6688026051;

    typedef enum logic {CM_VEC, CM_ROT} cordic_mode_t;

    typedef struct packed {
        logic         start;
        cordic_mode_t mode;
    } cordic_ctl_t;

    typedef enum logic {DS_DIV, DS_SQRT} ds_mode_t;

    typedef struct packed {
        logic     start;
        ds_mode_t mode;
    } ds_ctl_t;

    // Micro-rotation angle for step i, Q30.
    function automatic logic signed [35:0] atan_step(input logic [4:0] i);
        logic signed [35:0] v;
        case (i)
            5'd0:    v = 36'sd843314857;
            5'd1:    v = 36'sd497837829;
            5'd2:    v = 36'sd263043837;
            5'd3:    v = 36'sd133525159;
            5'd4:    v = 36'sd67021687;
            5'd5:    v = 36'sd33543516;
            5'd6:    v = 36'sd16775851;
            5'd7:    v = 36'sd8388437;
            5'd8:    v = 36'sd4194283;
            5'd9:    v = 36'sd2097149;
            5'd10:   v = 36'sd1048576;
            default: v = 36'sd1 <<< (5'd30 - i);
        endcase
        return v;
    endfunction

    // Drops 30 fraction bits, rounding half away from zero.
    function automatic logic signed [39:0] rnd30(input logic signed [68:0] v);
        logic [68:0] m;
        logic [68:0] r;
        m = v[68] ? 69'(-v) : 69'(v);
        r = (m + (69'd1 << 29)) >> 30;
        return v[68] ? -$signed(r[39:0]) : $signed(r[39:0]);
    endfunction

endpackage

>>> rtl/core/e2g_ifs.sv
// ============================================================================
// e2g_ifs: request and result channels of the converter
// Valid/ready channels carrying one position request and one geodetic result.
// ============================================================================
interface e2g_pos_if;
    logic               valid;
    logic               ready;
    logic signed [40:0] pos_x;
    logic signed [40:0] pos_y;
    logic signed [40:0] pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface e2g_geo_if;
    logic               valid;
    logic               ready;
    logic signed [32:0] latitude;
    logic signed [32:0] longitude;
    logic signed [40:0] altitude;

    modport source (output valid, output latitude, output longitude, output altitude,
                    input ready);
    modport sink   (input valid, input latitude, input longitude, input altitude,
                    output ready);
endinterface

>>> rtl/core/ecef_to_geodetic_unit.sv
// ============================================================================
// ecef_to_geodetic_unit: Earth-fixed position to geodetic coordinates
// Sequencer around a shared CORDIC, divider/square root and multiplier.
// ============================================================================
// Usage. A request on the pos channel carries x, y and z in Q20 km. The
// result on the geo channel carries latitude and longitude in Q30 radians
// and altitude in Q20 km. Both channels move data when valid and ready are
// high together at a rising clock edge.
// The block works on one request at a time; pos.ready is high only while the
// sequencer is idle. A request runs up to max_iterations minus one latitude
// refinements after its first estimate. Each refinement is dominated by a
// 31-step rotation, a 31-step square root and a 72-step division on the
// shared units, followed by a vectoring pass. A new request is taken only
// once the sequencer has handed the previous result to the output register.
// The result sits in an output register, so the next request is taken while
// an earlier result still waits; if the receiver stalls for longer than a
// whole request, the sequencer holds its finished result until the register
// frees. Configuration is written through cfg_we, cfg_index and cfg_data and
// must only change while idle. Reset returns the sequencer to idle, drops any
// pending result and restores the register defaults.
// ============================================================================
module ecef_to_geodetic_unit
    import e2g_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    e2g_pos_if.sink     pos,
    e2g_geo_if.source   geo,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [33:0] cfg_data
);

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_MAX_ITER = 2'd0;
    localparam logic [1:0] CFG_TOL      = 2'd1;
    localparam logic [1:0] CFG_RADIUS   = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_LON_GO, S_LON_WAIT, S_LON_MHI, S_LON_MLO, S_LON_FIN,
        S_LAT_GO, S_LAT_WAIT, S_RAD_GO, S_RAD_WAIT, S_RAD_SQ, S_RAD_E2,
        S_RAD_D, S_RAD_SQWAIT, S_RAD_DIVWAIT, S_CHECK, S_LP_M1, S_LP_M2,
        S_LP_NUM, S_LP_WAIT, S_FIN_GO, S_FIN_WAIT, S_FIN_SEL, S_FIN_DIVGO,
        S_FIN_DIV, S_FIN_ALT
    } state_t;

    state_t             state_reg;
    logic [5:0]         max_it_reg;
    logic [33:0]        tol_reg;
    logic [32:0]        re_reg;

    logic signed [40:0] px_reg, py_reg, pz_reg;
    logic signed [42:0] h_reg;
    logic signed [35:0] lonang_reg, lon_reg, lat_reg, delta_reg;
    logic [33:0]        c_reg;
    logic signed [32:0] s_reg, co_reg;
    logic [5:0]         iter_reg;
    logic               loop_reg;
    logic [63:0]        ux_reg;
    logic [5:0]         k_reg;
    logic [63:0]        thi_reg;
    logic signed [68:0] prod_reg;
    logic               polar_reg;
    logic               neg_reg;
    logic [41:0]        nmag_reg;
    logic [31:0]        den_reg;
    logic [34:0]        term_reg;
    logic [62:0]        q_reg;

    logic               out_valid_reg;
    logic signed [32:0] out_lat_reg, out_lon_reg;
    logic signed [40:0] out_alt_reg;

    // Shared unit controls.
    cordic_ctl_t        cord_ctl;
    logic signed [42:0] cord_a, cord_b;
    logic signed [35:0] cord_ang;
    logic               cord_done;
    logic signed [63:0] cord_x, cord_y;
    logic signed [35:0] cord_z;
    logic [5:0]         cord_k;

    ds_ctl_t            ds_ctl;
    logic [71:0]        ds_num;
    logic [31:0]        ds_den;
    logic [61:0]        ds_rad;
    logic               ds_done;
    logic [71:0]        ds_quot;
    logic [31:0]        ds_rem;
    logic [30:0]        ds_root;

    logic signed [35:0] mul_a;
    logic signed [32:0] mul_b;
    logic               mul_en;

    // Derived values.
    logic signed [39:0] rnd_val, d_val;
    logic               d_pos;
    logic signed [68:0] rup_val;
    logic signed [42:0] num_val;
    logic [63:0]        t_sum, hv;
    logic               tiny;
    logic signed [35:0] lon_pre, lon_wrap, alat;
    logic               nonpolar;
    logic signed [36:0] diff, adiff;
    logic               conv;
    logic [32:0]        co_mag, si_mag;
    logic [40:0]        z_mag;
    logic signed [63:0] qs, alt64;
    logic signed [40:0] alt_sat;
    logic               out_free;

    e2g_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cord_ctl),
        .a     (cord_a),
        .b     (cord_b),
        .ang   (cord_ang),
        .done  (cord_done),
        .x_out (cord_x),
        .y_out (cord_y),
        .z_out (cord_z),
        .k_out (cord_k)
    );

    e2g_divsqrt u_divsqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ds_ctl),
        .num   (ds_num),
        .den   (ds_den),
        .rad   (ds_rad),
        .done  (ds_done),
        .quot  (ds_quot),
        .rem   (ds_rem),
        .root  (ds_root)
    );

    // Arithmetic between the registers that feed the sequencer.
    always_comb
    begin
        rnd_val = rnd30(prod_reg);
        d_val   = ONE_Q30 - rnd_val;
        d_pos   = !d_val[39] && (d_val != '0);
        rup_val = (prod_reg + (69'sd1 <<< 29)) >>> 30;
        num_val = 43'(pz_reg) + 43'(rnd_val);

        // Magnitude gain correction, then the normalising shift is undone
        // with rounding half up.
        t_sum = thi_reg + {31'b0, prod_reg[64:32]};
        hv    = (t_sum + ((64'd1 << k_reg) >> 1)) >> k_reg;
        tiny  = {hv[42:0], 10'b0} < {19'b0, tol_reg};

        lon_pre = tiny ? (pz_reg[40] ? -HALFPI_Q30 : HALFPI_Q30) : lonang_reg;
        if (lon_pre >= PI_Q30)
            lon_wrap = lon_pre - TWOPI_Q30;
        else if (lon_pre <= -PI_Q30)
            lon_wrap = lon_pre + TWOPI_Q30;
        else
            lon_wrap = lon_pre;

        diff  = 37'(delta_reg) - 37'(lat_reg);
        adiff = diff[36] ? -diff : diff;
        conv  = ($unsigned(adiff) < {3'b0, tol_reg}) || (iter_reg >= max_it_reg);

        alat     = lat_reg[35] ? -lat_reg : lat_reg;
        nonpolar = (HALFPI_Q30 - alat) > DEG_Q30;
        co_mag   = co_reg[32] ? 33'(-co_reg) : 33'(co_reg);
        si_mag   = s_reg[32] ? 33'(-s_reg) : 33'(s_reg);
        z_mag    = pz_reg[40] ? 41'(-pz_reg) : 41'(pz_reg);

        qs    = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        alt64 = qs - $signed({29'b0, term_reg});
        if (alt64 > ALT_MAX)
            alt_sat = ALT_MAX[40:0];
        else if (alt64 < ALT_MIN)
            alt_sat = ALT_MIN[40:0];
        else
            alt_sat = alt64[40:0];

        out_free = !out_valid_reg || geo.ready;
    end

    // Operand selection for the shared units, by sequencer state.
    always_comb
    begin
        mul_en        = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        cord_ctl      = '{start: 1'b0, mode: CM_VEC};
        cord_a        = h_reg;
        cord_b        = 43'(pz_reg);
        cord_ang      = lat_reg;
        ds_ctl        = '{start: 1'b0, mode: DS_DIV};
        ds_num        = {nmag_reg, 30'b0};
        ds_den        = den_reg;
        ds_rad        = {d_val[31:0], 30'b0};
        case (state_reg)
            S_LON_GO:
            begin
                cord_ctl = '{start: 1'b1, mode: CM_VEC};
                cord_a   = 43'(px_reg);
                cord_b   = 43'(py_reg);
            end
            S_LAT_GO:
            begin
                cord_ctl = '{start: 1'b1, mode: CM_VEC};
            end
            S_LON_MHI:
            begin
                mul_en = 1'b1;
                mul_a  = $signed({4'b0, ux_reg[63:32]});
                mul_b  = KGAIN_Q32;
            end
            S_LON_MLO:
            begin
                mul_en = 1'b1;
                mul_a  = $signed({4'b0, ux_reg[31:0]});
                mul_b  = KGAIN_Q32;
            end
            S_RAD_GO, S_FIN_GO:
            begin
                cord_ctl = '{start: 1'b1, mode: CM_ROT};
            end
            S_RAD_SQ:
            begin
                mul_en = 1'b1;
                mul_a  = 36'(s_reg);
                mul_b  = s_reg;
            end
            S_RAD_E2:
            begin
                mul_en = 1'b1;
                mul_a  = 36'(E2_Q30);
                mul_b  = rnd_val[32:0];
            end
            S_RAD_D:
            begin
                ds_ctl = '{start: d_pos, mode: DS_SQRT};
            end
            S_RAD_SQWAIT:
            begin
                ds_ctl = '{start: ds_done && (ds_root != '0), mode: DS_DIV};
                ds_num = ({39'b0, re_reg} << 30) + {41'b0, ds_root >> 1};
                ds_den = {1'b0, ds_root};
            end
            S_LP_M1:
            begin
                mul_en = 1'b1;
                mul_a  = $signed({2'b0, c_reg});
                mul_b  = E2_Q30;
            end
            S_LP_M2:
            begin
                mul_en = 1'b1;
                mul_a  = rup_val[35:0];
                mul_b  = s_reg;
            end
            S_LP_NUM:
            begin
                cord_ctl = '{start: (h_reg != '0), mode: CM_VEC};
                cord_b   = num_val;
            end
            S_FIN_SEL:
            begin
                mul_en = 1'b1;
                mul_a  = $signed({2'b0, c_reg});
                mul_b  = OMEGA_Q30;
            end
            S_FIN_DIVGO:
            begin
                ds_ctl = '{start: (den_reg != '0), mode: DS_DIV};
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_it_reg <= MAXIT_RESET;
            tol_reg    <= TOL_RESET;
            re_reg     <= RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_ITER: max_it_reg <= cfg_data[5:0];
                CFG_TOL:      tol_reg    <= cfg_data;
                CFG_RADIUS:   re_reg     <= cfg_data[32:0];
                default:      max_it_reg <= max_it_reg;
            endcase
        end
    end

    // Shared multiplier with its product register.
    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= 69'(mul_a) * 69'(mul_b);
    end

    // Sequencer and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            loop_reg      <= 1'b0;
        end
        else
        begin
            // The altitude step reloads the result register itself.
            if (out_valid_reg && geo.ready && (state_reg != S_FIN_ALT))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (pos.valid)
                    begin
                        px_reg    <= pos.pos_x;
                        py_reg    <= pos.pos_y;
                        pz_reg    <= pos.pos_z;
                        loop_reg  <= 1'b0;
                        state_reg <= S_LON_GO;
                    end
                end
                S_LON_GO:   state_reg <= S_LON_WAIT;
                S_LON_WAIT:
                begin
                    if (cord_done)
                    begin
                        lonang_reg <= cord_z;
                        ux_reg     <= cord_x[63] ? 64'd0 : cord_x;
                        k_reg      <= cord_k;
                        state_reg  <= S_LON_MHI;
                    end
                end
                S_LON_MHI:  state_reg <= S_LON_MLO;
                S_LON_MLO:
                begin
                    thi_reg   <= prod_reg[63:0];
                    state_reg <= S_LON_FIN;
                end
                S_LON_FIN:
                begin
                    h_reg     <= $signed(hv[42:0]);
                    lon_reg   <= lon_wrap;
                    state_reg <= S_LAT_GO;
                end
                S_LAT_GO:   state_reg <= S_LAT_WAIT;
                S_LAT_WAIT:
                begin
                    if (cord_done)
                    begin
                        lat_reg   <= cord_z;
                        delta_reg <= cord_z + TEN_Q30;
                        iter_reg  <= 6'd1;
                        state_reg <= S_RAD_GO;
                    end
                end
                // Prime-vertical radius at the current latitude.
                S_RAD_GO:   state_reg <= S_RAD_WAIT;
                S_RAD_WAIT:
                begin
                    if (cord_done)
                    begin
                        s_reg     <= cord_y[32:0];
                        state_reg <= S_RAD_SQ;
                    end
                end
                S_RAD_SQ:   state_reg <= S_RAD_E2;
                S_RAD_E2:   state_reg <= S_RAD_D;
                S_RAD_D:
                begin
                    if (d_pos)
                    begin
                        state_reg <= S_RAD_SQWAIT;
                    end
                    else
                    begin
                        c_reg     <= {1'b0, re_reg};
                        state_reg <= loop_reg ? S_LP_M1 : S_CHECK;
                    end
                end
                S_RAD_SQWAIT:
                begin
                    if (ds_done)
                    begin
                        if (ds_root != '0)
                        begin
                            state_reg <= S_RAD_DIVWAIT;
                        end
                        else
                        begin
                            c_reg     <= {1'b0, re_reg};
                            state_reg <= loop_reg ? S_LP_M1 : S_CHECK;
                        end
                    end
                end
                S_RAD_DIVWAIT:
                begin
                    if (ds_done)
                    begin
                        c_reg     <= ds_quot[33:0];
                        state_reg <= loop_reg ? S_LP_M1 : S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (conv)
                    begin
                        state_reg <= S_FIN_GO;
                    end
                    else
                    begin
                        delta_reg <= lat_reg;
                        loop_reg  <= 1'b1;
                        state_reg <= S_RAD_GO;
                    end
                end
                S_LP_M1:    state_reg <= S_LP_M2;
                S_LP_M2:    state_reg <= S_LP_NUM;
                S_LP_NUM:
                begin
                    if (h_reg == '0)
                    begin
                        // No horizontal distance: the latitude goes to a pole.
                        lat_reg   <= num_val[42] ? -HALFPI_Q30 : HALFPI_Q30;
                        iter_reg  <= iter_reg + 6'd1;
                        state_reg <= S_CHECK;
                    end
                    else
                    begin
                        state_reg <= S_LP_WAIT;
                    end
                end
                S_LP_WAIT:
                begin
                    if (cord_done)
                    begin
                        lat_reg   <= cord_z;
                        iter_reg  <= iter_reg + 6'd1;
                        state_reg <= S_CHECK;
                    end
                end
                S_FIN_GO:   state_reg <= S_FIN_WAIT;
                S_FIN_WAIT:
                begin
                    if (cord_done)
                    begin
                        co_reg    <= cord_x[32:0];
                        s_reg     <= cord_y[32:0];
                        state_reg <= S_FIN_SEL;
                    end
                end
                S_FIN_SEL:
                begin
                    // Cosine form away from the poles, sine form near them.
                    polar_reg <= !nonpolar;
                    if (nonpolar)
                    begin
                        nmag_reg <= h_reg[41:0];
                        den_reg  <= co_mag[31:0];
                        neg_reg  <= co_reg[32];
                    end
                    else
                    begin
                        nmag_reg <= {1'b0, z_mag};
                        den_reg  <= si_mag[31:0];
                        neg_reg  <= pz_reg[40] ^ s_reg[32];
                    end
                    state_reg <= S_FIN_DIVGO;
                end
                S_FIN_DIVGO:
                begin
                    term_reg <= polar_reg ? rup_val[34:0] : {1'b0, c_reg};
                    if (den_reg == '0)
                    begin
                        q_reg     <= QCAP;
                        state_reg <= S_FIN_ALT;
                    end
                    else
                    begin
                        state_reg <= S_FIN_DIV;
                    end
                end
                S_FIN_DIV:
                begin
                    if (ds_done)
                    begin
                        if (ds_quot >= {9'b0, QCAP})
                            q_reg <= QCAP;
                        else
                            q_reg <= ds_quot[62:0]
                                   + {62'b0, ({ds_rem, 1'b0} >= {1'b0, den_reg})};
                        state_reg <= S_FIN_ALT;
                    end
                end
                S_FIN_ALT:
                begin
                    if (out_free)
                    begin
                        out_lat_reg   <= lat_reg[32:0];
                        out_lon_reg   <= lon_reg[32:0];
                        out_alt_reg   <= alt_sat;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign pos.ready     = (state_reg == S_IDLE);
    assign geo.valid     = out_valid_reg;
    assign geo.latitude  = out_lat_reg;
    assign geo.longitude = out_lon_reg;
    assign geo.altitude  = out_alt_reg;

`ifndef ASSERT_OFF
    // An accepted request always leaves the sequencer busy.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (pos.valid && pos.ready) |=> (state_reg != S_IDLE))
        else $error("sequencer idle right after accepting a request");

    // A result appears only from the final altitude step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(geo.valid) |-> $past(state_reg == S_FIN_ALT))
        else $error("result raised outside the altitude step");

    // The divider is never started with a zero divisor.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (ds_ctl.start && ds_ctl.mode == DS_DIV) |-> (ds_den != '0))
        else $error("division started with a zero divisor");
`endif

endmodule

>>> rtl/core/e2g_cordic.sv
// ============================================================================
// e2g_cordic: iterative CORDIC engine
// Vectoring (atan2 and raw magnitude) or rotation (cos and sin), one step a cycle.
// ============================================================================
module e2g_cordic
    import e2g_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cordic_ctl_t        ctl,
    input  logic signed [42:0] a,
    input  logic signed [42:0] b,
    input  logic signed [35:0] ang,
    output logic               done,
    output logic signed [63:0] x_out,
    output logic signed [63:0] y_out,
    output logic signed [35:0] z_out,
    output logic [5:0]         k_out
);

    typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER} cstate_t;

    cstate_t            state_reg;
    cordic_mode_t       mode_reg;
    logic signed [63:0] x_reg, y_reg;
    logic signed [35:0] z_reg;
    logic [63:0]        m_reg;
    logic [5:0]         k_reg;
    logic [4:0]         i_reg;
    logic               done_reg;

    logic signed [63:0] xs, ys;
    logic signed [35:0] at;
    logic               up;
    logic [42:0]        a_mag, b_mag;

    always_comb
    begin
        xs    = x_reg >>> i_reg;
        ys    = y_reg >>> i_reg;
        at    = atan_step(i_reg);
        up    = (mode_reg == CM_VEC) ? ~y_reg[63] : z_reg[35];
        a_mag = a[42] ? 43'(-a) : 43'(a);
        b_mag = b[42] ? 43'(-b) : 43'(b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    if (ctl.start)
                    begin
                        mode_reg <= ctl.mode;
                        i_reg    <= '0;
                        k_reg    <= '0;
                        if (ctl.mode == CM_VEC)
                        begin
                            if (a == '0 && b == '0)
                            begin
                                x_reg    <= '0;
                                y_reg    <= '0;
                                z_reg    <= '0;
                                done_reg <= 1'b1;
                            end
                            else
                            begin
                                x_reg     <= 64'(a);
                                y_reg     <= 64'(b);
                                z_reg     <= '0;
                                m_reg     <= 64'((a_mag > b_mag) ? a_mag : b_mag);
                                state_reg <= C_NORM;
                            end
                        end
                        else
                        begin
                            x_reg     <= KGAIN_Q30;
                            y_reg     <= '0;
                            z_reg     <= ang;
                            state_reg <= C_ITER;
                        end
                    end
                end
                C_NORM:
                begin
                    // Bring the larger operand into [2^58, 2^59), coarse steps first.
                    if (m_reg[63:51] == '0)
                    begin
                        m_reg <= m_reg << 8;
                        x_reg <= x_reg <<< 8;
                        y_reg <= y_reg <<< 8;
                        k_reg <= k_reg + 6'd8;
                    end
                    else if (m_reg[63:58] == '0)
                    begin
                        m_reg <= m_reg << 1;
                        x_reg <= x_reg <<< 1;
                        y_reg <= y_reg <<< 1;
                        k_reg <= k_reg + 6'd1;
                    end
                    else
                    begin
                        // The left half plane is turned by a quarter first.
                        if (x_reg[63])
                        begin
                            if (!y_reg[63])
                            begin
                                x_reg <= y_reg;
                                y_reg <= -x_reg;
                                z_reg <= HALFPI_Q30;
                            end
                            else
                            begin
                                x_reg <= -y_reg;
                                y_reg <= x_reg;
                                z_reg <= -HALFPI_Q30;
                            end
                        end
                        state_reg <= C_ITER;
                    end
                end
                C_ITER:
                begin
                    x_reg <= up ? x_reg + ys : x_reg - ys;
                    y_reg <= up ? y_reg - xs : y_reg + xs;
                    z_reg <= up ? z_reg + at : z_reg - at;
                    if (i_reg == 5'd30)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end
                    else
                    begin
                        i_reg <= i_reg + 5'd1;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
    assign k_out = k_reg;

endmodule

>>> rtl/core/e2g_divsqrt.sv
// ============================================================================
// e2g_divsqrt: shared bit-serial divider and square root
// Restoring division of a 72-bit dividend and a floor integer square root.
// ============================================================================
module e2g_divsqrt
    import e2g_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ds_ctl_t     ctl,
    input  logic [71:0] num,
    input  logic [31:0] den,
    input  logic [61:0] rad,
    output logic        done,
    output logic [71:0] quot,
    output logic [31:0] rem,
    output logic [30:0] root
);

    typedef enum logic [1:0] {D_IDLE, D_DIV, D_SQRT} dstate_t;

    dstate_t     state_reg;
    logic [6:0]  cnt_reg;
    logic [71:0] q_reg;
    logic [31:0] r_reg;
    logic [31:0] d_reg;
    logic [61:0] v_reg;
    logic [61:0] sr_reg;
    logic        done_reg;

    logic [32:0] trial;
    logic        fits;
    logic [61:0] bitv;
    logic [61:0] rb;

    always_comb
    begin
        trial = {r_reg, q_reg[71]};
        fits  = (trial >= {1'b0, d_reg});
        bitv  = 62'd1 << {cnt_reg[4:0], 1'b0};
        rb    = sr_reg + bitv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (ctl.start)
                    begin
                        if (ctl.mode == DS_DIV)
                        begin
                            q_reg     <= num;
                            r_reg     <= '0;
                            d_reg     <= den;
                            cnt_reg   <= 7'd71;
                            state_reg <= D_DIV;
                        end
                        else
                        begin
                            v_reg     <= rad;
                            sr_reg    <= '0;
                            cnt_reg   <= 7'd30;
                            state_reg <= D_SQRT;
                        end
                    end
                end
                D_DIV:
                begin
                    r_reg <= fits ? 32'(trial - {1'b0, d_reg}) : trial[31:0];
                    q_reg <= {q_reg[70:0], fits};
                    if (cnt_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                    cnt_reg <= cnt_reg - 7'd1;
                end
                D_SQRT:
                begin
                    if (v_reg >= rb)
                    begin
                        v_reg  <= v_reg - rb;
                        sr_reg <= (sr_reg >> 1) + bitv;
                    end
                    else
                    begin
                        sr_reg <= sr_reg >> 1;
                    end
                    if (cnt_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                    cnt_reg <= cnt_reg - 7'd1;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;
    assign root = sr_reg[30:0];

endmodule

>>> sim/tb_ecef_to_geodetic_unit.sv
// ----------------------------------------------------------------------------
// tb_ecef_to_geodetic_unit: self-checking bench for the ECEF to geodetic unit
// Drives position requests with random gaps, predicts latitude, longitude and
// altitude with a bit-exact fixed-point model of its own, and compares every
// result in order across several register settings.
// ----------------------------------------------------------------------------
module tb_ecef_to_geodetic_unit;
    import e2g_pkg::*;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_MAX_ITER = 2'd0;
    localparam logic [1:0] REG_TOL      = 2'd1;
    localparam logic [1:0] REG_RADIUS   = 2'd2;

    // Fixed-point constants of the conversion, Q30 unless noted otherwise.
    localparam longint C_PI     = 64'sd3373259426;
    localparam longint C_HALFPI = 64'sd1686629713;
    localparam longint C_TWOPI  = 64'sd6746518852;
    localparam longint C_DEG    = 64'sd18740330;
    localparam longint C_TEN    = 64'sd10737418240;
    localparam longint C_ONE    = 64'sd1073741824;
    localparam longint C_ECC2   = 64'sd7188041;
    localparam longint C_GAIN30 = 64'sd652032874;
    localparam longint unsigned C_GAIN32 = 64'd2608131496;
    localparam longint unsigned C_QCAP   = 64'd1 << 62;
    localparam longint C_ALT_HI = 64'sd1099511627775;
    localparam longint C_ALT_LO = -64'sd1099511627776;

    // The longest request runs 62 refinements, so a silence of this length can
    // only mean that the block has hung.
    localparam int WATCHDOG_CYCLES = 60000;

    typedef struct {
        logic signed [40:0] x;
        logic signed [40:0] y;
        logic signed [40:0] z;
    } ecef_pos_t;

    typedef struct {
        logic signed [32:0] lat;
        logic signed [32:0] lon;
        logic signed [40:0] alt;
    } geodetic_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [33:0] cfg_data;

    e2g_pos_if pos_if();
    e2g_geo_if geo_if();

    ecef_to_geodetic_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pos       (pos_if),
        .geo       (geo_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copies of the three registers, as the predictor sees them.
    logic [5:0]  sh_max_iter;
    logic [32:0] sh_radius;
    logic [33:0] sh_tol;

    ecef_pos_t pending_pos_q[$];
    geodetic_t expected_geo_q[$];
    int        error_count;
    int        quiet_cycles;
    bit        no_gaps;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------------
    // Predictor. Everything below is held in 64-bit words, which is wide
    // enough for every intermediate value once the operands are normalised.
    // ------------------------------------------------------------------------
    function automatic longint micro_angle(input int i);
        longint tab[0:10];
        tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                16775851, 8388437, 4194283, 2097149, 1048576};
        return (i <= 10) ? tab[i] : (64'sd1 <<< (30 - i));
    endfunction

    // Magnitude rounded half away from zero after dropping s fraction bits.
    function automatic longint round_drop(input longint v, input int s);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : v;
        m = (m + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Vectoring: angle of (a, b) and its gain-corrected length.
    function automatic void vector_polar(input longint a, input longint b,
                                         output longint ang, output longint mag);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned m;
        longint unsigned ux;
        longint unsigned t;
        longint x;
        longint y;
        longint z;
        longint nx;
        int k;
        if (a == 0 && b == 0)
        begin
            ang = 0;
            mag = 0;
            return;
        end
        ma = (a < 0) ? longint'(-a) : a;
        mb = (b < 0) ? longint'(-b) : b;
        m = (ma > mb) ? ma : mb;
        k = 0;
        while (m < (64'd1 << 58))
        begin
            m <<= 1;
            k++;
        end
        x = a <<< k;
        y = b <<< k;
        z = 0;
        // Vectors in the left half plane are turned by a quarter first.
        if (x < 0)
        begin
            if (y >= 0)
            begin
                nx = y;
                y = -x;
                x = nx;
                z = C_HALFPI;
            end
            else
            begin
                nx = -y;
                y = x;
                x = nx;
                z = -C_HALFPI;
            end
        end
        for (int i = 0; i < 31; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += micro_angle(i);
            end
            else
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= micro_angle(i);
            end
            x = nx;
        end
        ang = z;
        ux = (x > 0) ? x : 0;
        t = (ux >> 32) * C_GAIN32 + (((ux & 64'hFFFF_FFFF) * C_GAIN32) >> 32);
        if (k > 0)
            t = (t + (64'd1 << (k - 1))) >> k;
        mag = t;
    endfunction

    function automatic void rotate_unit(input longint ang, output longint co,
                                        output longint si);
        longint x;
        longint y;
        longint z;
        longint nx;
        x = C_GAIN30;
        y = 0;
        z = ang;
        for (int i = 0; i < 31; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= micro_angle(i);
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += micro_angle(i);
            end
            x = nx;
        end
        co = x;
        si = y;
    endfunction

    // n * 2^30 / d on magnitudes, rounded half up and capped at 2^62.
    function automatic longint unsigned scaled_quotient(input longint unsigned n,
                                                        input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        if (d == 0)
            return C_QCAP;
        if (d >= C_QCAP)
            return 0;
        q = n / d;
        r = n % d;
        if (q >= C_QCAP)
            return C_QCAP;
        for (int i = 0; i < 30; i++)
        begin
            r <<= 1;
            q <<= 1;
            if (r >= d)
            begin
                r -= d;
                q |= 1;
            end
            if (q >= C_QCAP)
                return C_QCAP;
        end
        if (2 * r >= d)
            q++;
        return q;
    endfunction

    function automatic longint signed_quotient(input longint n, input longint d);
        longint q;
        q = scaled_quotient((n < 0) ? longint'(-n) : n, (d < 0) ? longint'(-d) : d);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    // Prime-vertical radius (Q20) at a latitude; the sine comes back as well.
    function automatic longint unsigned vertical_radius(input longint lat,
                                                        output longint s);
        longint co;
        longint si;
        longint e;
        longint d;
        longint unsigned q;
        longint unsigned re;
        re = sh_radius;
        rotate_unit(lat, co, si);
        s = si;
        e = round_drop(C_ECC2 * round_drop(si * si, 30), 30);
        d = C_ONE - e;
        if (d <= 0)
            return re;
        q = floor_sqrt(longint'(d) << 30);
        if (q == 0)
            return re;
        return ((re << 30) + (q >> 1)) / q;
    endfunction

    function automatic geodetic_t solve_geodetic(input ecef_pos_t p);
        geodetic_t g;
        longint x;
        longint y;
        longint z;
        longint lon_ang;
        longint h;
        longint lon;
        longint lat;
        longint unused_mag;
        longint prev;
        longint s;
        longint diff;
        longint co;
        longint si;
        longint alt;
        longint ce2;
        longint num;
        longint unsigned c;
        int unsigned pass_no;
        x = p.x;
        y = p.y;
        z = p.z;

        vector_polar(x, y, lon_ang, h);
        if ((longint'(h) << 10) < 64'(sh_tol))
            lon = (z < 0) ? -C_HALFPI : C_HALFPI;
        else
            lon = lon_ang;
        if (lon >= C_PI)
            lon -= C_TWOPI;
        else if (lon <= -C_PI)
            lon += C_TWOPI;

        // Starting latitude, then the ellipsoid refinement.
        vector_polar(h, z, lat, unused_mag);
        c = vertical_radius(lat, s);
        prev = lat + C_TEN;
        pass_no = 1;
        while (1)
        begin
            diff = prev - lat;
            if (diff < 0)
                diff = -diff;
            if (longint'(diff) < 64'(sh_tol) || pass_no >= sh_max_iter)
                break;
            prev = lat;
            c = vertical_radius(lat, s);
            ce2 = (c * C_ECC2 + (64'd1 << 29)) >> 30;
            num = z + round_drop(ce2 * s, 30);
            if (h == 0)
                lat = (num < 0) ? -C_HALFPI : C_HALFPI;
            else
                vector_polar(h, num, lat, unused_mag);
            pass_no++;
        end

        rotate_unit(lat, co, si);
        if (C_HALFPI - ((lat < 0) ? -lat : lat) > C_DEG)
            alt = signed_quotient(h, co) - longint'(c);
        else
            alt = signed_quotient(z, si) -
                  longint'((c * (C_ONE - C_ECC2) + (64'd1 << 29)) >> 30);
        if (alt > C_ALT_HI)
            alt = C_ALT_HI;
        if (alt < C_ALT_LO)
            alt = C_ALT_LO;

        g.lat = lat[32:0];
        g.lon = lon[32:0];
        g.alt = alt[40:0];
        return g;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic longint span_rand(input longint lim);
        longint unsigned r;
        r = {$urandom, $urandom};
        return longint'(r % longint'(2 * lim + 1)) - lim;
    endfunction

    function automatic ecef_pos_t make_pos(input longint x, input longint y,
                                           input longint z);
        ecef_pos_t p;
        p.x = x[40:0];
        p.y = y[40:0];
        p.z = z[40:0];
        return p;
    endfunction

    // Random positions: close to half in the band around the Earth where the
    // refinement actually converges, the rest spread over the whole range,
    // hugging the polar axis or tiny.
    function automatic ecef_pos_t random_pos();
        int unsigned kind;
        longint earth;
        longint w;
        kind = $urandom_range(0, 99);
        earth = 64'sd7400 <<< 20;
        if (kind < 45)
            return make_pos(span_rand(earth), span_rand(earth), span_rand(earth));
        else if (kind < 70)
            return make_pos({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom});
        else if (kind < 85)
        begin
            w = 64'sd1 <<< $urandom_range(0, 14);
            return make_pos(span_rand(w), span_rand(w), span_rand(earth));
        end
        else
        begin
            w = 64'sd1 <<< $urandom_range(0, 24);
            return make_pos(span_rand(w), span_rand(w), span_rand(w));
        end
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. A new gap length is drawn for every request; when
    // no_gaps is set the requests go back to back.
    // ------------------------------------------------------------------------
    int req_gap;

    always @(posedge clk or negedge rst_n)
    begin
        ecef_pos_t p;
        logic      next_valid;
        if (!rst_n)
        begin
            pos_if.valid <= 1'b0;
            pos_if.pos_x <= '0;
            pos_if.pos_y <= '0;
            pos_if.pos_z <= '0;
            req_gap = 0;
        end
        else
        begin
            next_valid = pos_if.valid;
            if (pos_if.valid && pos_if.ready)
            begin
                p.x = pos_if.pos_x;
                p.y = pos_if.pos_y;
                p.z = pos_if.pos_z;
                expected_geo_q.push_back(solve_geodetic(p));
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (req_gap > 0)
                    req_gap--;
                else if (pending_pos_q.size() > 0)
                begin
                    p = pending_pos_q.pop_front();
                    pos_if.pos_x <= p.x;
                    pos_if.pos_y <= p.y;
                    pos_if.pos_z <= p.z;
                    next_valid = 1'b1;
                    req_gap = no_gaps ? 0 : $urandom_range(0, 10);
                end
            end
            pos_if.valid <= next_valid;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor with random back-pressure, plus the watchdog.
    // ------------------------------------------------------------------------
    int res_stall;

    always @(posedge clk or negedge rst_n)
    begin
        geodetic_t g;
        logic      take;
        if (!rst_n)
        begin
            geo_if.ready <= 1'b0;
            res_stall = 0;
            quiet_cycles = 0;
        end
        else
        begin
            take = geo_if.valid && geo_if.ready;
            if (take)
            begin
                if (expected_geo_q.size() == 0)
                begin
                    $error("result arrived with no request outstanding");
                    error_count++;
                end
                else
                begin
                    g = expected_geo_q.pop_front();
                    check_field("latitude", g.lat, geo_if.latitude);
                    check_field("longitude", g.lon, geo_if.longitude);
                    check_field("altitude", g.alt, geo_if.altitude);
                end
                res_stall = no_gaps ? 0 : $urandom_range(0, 10);
            end
            else if (res_stall > 0)
                res_stall--;
            geo_if.ready <= (res_stall == 0);

            if (take || (pos_if.valid && pos_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES)
            begin
                $display("ecef_to_geodetic_unit verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence of the run: reset, then one phase per register setting. The
    // registers are only touched once the block has gone idle.
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [33:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_MAX_ITER: sh_max_iter = value[5:0];
            REG_TOL:      sh_tol      = value;
            default:      sh_radius   = value[32:0];
        endcase
    endtask

    task automatic wait_idle();
        while (pending_pos_q.size() > 0 || pos_if.valid || expected_geo_q.size() > 0)
            @(posedge clk);
        // Spare cycles for the sequencer to settle back to idle.
        repeat (5) @(posedge clk);
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            // Every fifty or so requests the idling switches on or off.
            if ($urandom_range(0, 49) == 0)
                no_gaps = !no_gaps;
            pending_pos_q.push_back(random_pos());
        end
    endtask

    initial
    begin
        longint top;
        longint bot;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_MAX_ITER;
        cfg_data    = '0;
        no_gaps     = 1'b0;
        error_count = 0;
        sh_max_iter = MAXIT_RESET;
        sh_tol      = TOL_RESET;
        sh_radius   = RADIUS_RESET;
        repeat (6) @(posedge clk);
        rst_n = 1'b1;

        // Directed corner cases under the reset settings.
        top = 64'sd1099511627775;
        bot = -64'sd1099511627776;
        pending_pos_q.push_back(make_pos(0, 0, 0));               // origin
        pending_pos_q.push_back(make_pos(0, 0, 64'sd6356 <<< 20)); // north pole
        pending_pos_q.push_back(make_pos(0, 0, -(64'sd6356 <<< 20)));
        pending_pos_q.push_back(make_pos(0, 0, top));
        pending_pos_q.push_back(make_pos(0, 0, bot));
        pending_pos_q.push_back(make_pos(top, 0, 0));
        pending_pos_q.push_back(make_pos(bot, 0, 0));             // lon near pi
        pending_pos_q.push_back(make_pos(bot, -1, 0));
        pending_pos_q.push_back(make_pos(0, top, 0));
        pending_pos_q.push_back(make_pos(0, bot, 0));
        pending_pos_q.push_back(make_pos(top, top, top));
        pending_pos_q.push_back(make_pos(bot, bot, bot));
        pending_pos_q.push_back(make_pos(-1, -1, -1));
        pending_pos_q.push_back(make_pos(64'sd6378 <<< 20, 0, 0)); // equator
        pending_pos_q.push_back(make_pos(-(64'sd4500 <<< 20), 64'sd4500 <<< 20, 0));
        // Horizontal distance just under the tolerance near the poles.
        pending_pos_q.push_back(make_pos(0, 1, 64'sd6356 <<< 20));
        pending_pos_q.push_back(make_pos(1, 0, -(64'sd6356 <<< 20)));
        // Within one degree of a pole, and just outside it.
        pending_pos_q.push_back(make_pos(64'sd80 <<< 20, 0, 64'sd6356 <<< 20));
        pending_pos_q.push_back(make_pos(64'sd130 <<< 20, 0, -(64'sd6356 <<< 20)));
        pending_pos_q.push_back(make_pos(64'sd3000 <<< 20, -(64'sd3000 <<< 20),
                                         64'sd4800 <<< 20));
        queue_random(230);
        wait_idle();

        // No refinement: limits of zero and one.
        write_reg(REG_MAX_ITER, 34'd0);
        @(posedge clk);
        cfg_we <= 1'b0;
        queue_random(130);
        wait_idle();

        write_reg(REG_MAX_ITER, 34'd1);
        @(posedge clk);
        cfg_we <= 1'b0;
        queue_random(110);
        wait_idle();

        // Highest limit but a tolerance so large the first check fails.
        write_reg(REG_MAX_ITER, 34'd63);
        write_reg(REG_TOL, 34'h2_7FFF_FFFF);
        @(posedge clk);
        cfg_we <= 1'b0;
        queue_random(120);
        wait_idle();

        // Zero tolerance: every refinement runs. Slow, so only a handful.
        write_reg(REG_TOL, 34'd0);
        write_reg(REG_RADIUS, 34'h1_FFFF_FFFF);
        @(posedge clk);
        cfg_we <= 1'b0;
        pending_pos_q.push_back(make_pos(0, 0, 64'sd6356 <<< 20));
        queue_random(12);
        wait_idle();

        // Zero radius with a short loop.
        write_reg(REG_MAX_ITER, 34'd4);
        write_reg(REG_RADIUS, 34'd0);
        @(posedge clk);
        cfg_we <= 1'b0;
        queue_random(160);
        wait_idle();

        write_reg(REG_MAX_ITER, 34'd6);
        write_reg(REG_TOL, 34'd1 << 20);
        write_reg(REG_RADIUS, 34'(RADIUS_RESET));
        @(posedge clk);
        cfg_we <= 1'b0;
        queue_random(150);
        wait_idle();

        // Back to the usual setting to finish.
        write_reg(REG_MAX_ITER, 34'(MAXIT_RESET));
        write_reg(REG_TOL, 34'(TOL_RESET));
        @(posedge clk);
        cfg_we <= 1'b0;
        queue_random(220);
        wait_idle();

        // Any stray result would show up within a whole request time.
        repeat (400) @(posedge clk);
        if (error_count == 0 && expected_geo_q.size() == 0)
            $display("ecef_to_geodetic_unit verification clean");
        else
            $display("ecef_to_geodetic_unit verification failed");
        $finish;
    end

endmodule
